FILE: src/s2lab_pkg.sv
// ============================================================================
// s2lab_pkg
// Shared types, fixed-point widths and the sRGB linearization table for the
// sRGB to CIELAB converter.
// ============================================================================
`default_nettype none

package s2lab_pkg;

	// Default output scaling (L, a, b times 2^OUT_FRAC_BITS)
	localparam int OUT_FRAC_BITS_DEF = 8;

	// Linear channel, Q0.16 with room for 1.0
	localparam int LIN_W = 17;
	// White-normalized XYZ ratio, Q16
	localparam int RATIO_W = 17;
	// CIELAB f() result, Q16
	localparam int F_W = 17;
	// Sum of matrix products, before the white-point division
	localparam int SUM_W = 30;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        [14:0] lightness;
		logic signed [15:0] green_red_axis;
		logic signed [15:0] blue_yellow_axis;
	} lab_t;

	typedef logic [LIN_W-1:0] lin_table_t [256];

	// One table entry: sRGB code to linear Q0.16.
	// Linear segment for small codes, else the 2.4 power built as
	// t^2 times the fifth root of t^2.
	function automatic logic [LIN_W-1:0] lin_entry(input int unsigned code);
		longint unsigned t;
		longint unsigned t2;
		longint unsigned target;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned res;
		if (code <= 10) begin
			res = (64'(code) * 64'd6553600 + 64'd164730) / 64'd329460;
		end else begin
			t = ((64'd1000 * 64'(code) + 64'd14025) << 30) / 64'd269025;
			t2 = (t * t + (64'd1 << 29)) >> 30;
			target = t2 << 30;
			lo = 64'd0;
			hi = 64'd4097;
			for (int i = 0; i < 14; i++) begin
				if (hi - lo > 64'd1) begin
					mid = (lo + hi) >> 1;
					if (mid * mid * mid * mid * mid <= target)
						lo = mid;
					else
						hi = mid;
				end
			end
			res = (t2 * lo + (64'd1 << 25)) >> 26;
		end
		return LIN_W'(res);
	endfunction

	function automatic lin_table_t lin_table_build();
		lin_table_t tab;
		for (int i = 0; i < 256; i++)
			tab[i] = lin_entry(i);
		return tab;
	endfunction

	localparam lin_table_t LIN_TABLE = lin_table_build();

endpackage

`default_nettype wire

FILE: src/srgb_to_cielab_converter_unit.sv
// ============================================================================
// srgb_to_cielab_converter_unit
// sRGB (8 bits a channel) to CIELAB, D65 white, fixed point.
//
// Input channel pix_*: one pixel per transfer (red, green, blue codes).
// Output channel lab_*: L, a, b scaled by 2^OUT_FRAC_BITS; a and b saturate.
// A transfer happens on a rising edge with valid high and stall low.
// Throughput: one pixel per clock while the output is not stalled. Between the input
// transfer and lab_valid lie the table, matrix, divider, f() (a 17-step
// cube root) and output stages.
// The pipeline advances as one; while a result sits on the output with
// lab_stall high, the whole pipeline holds and pix_stall is high, nothing is
// lost or repeated. pix_stall is low whenever the output is free.
// Reset (arst_n low) clears every valid bit; data registers are not reset.
// ============================================================================
`default_nettype none

module srgb_to_cielab_converter_unit #(
	parameter int OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire s2lab_pkg::pixel_t pix_data,
	output logic                   lab_valid,
	input  wire logic              lab_stall,
	output s2lab_pkg::lab_t        lab_data
);

	localparam int LW  = s2lab_pkg::LIN_W;
	localparam int SW  = s2lab_pkg::SUM_W;
	localparam int RW  = s2lab_pkg::RATIO_W;
	localparam int FW  = s2lab_pkg::F_W;
	// table + matrix + ratio division + f() + output
	localparam int LAT = 1 + 1 + 3 + 18 + 2;
	localparam int L_CAP = (100 << OUT_FRAC_BITS) < 32767 ? (100 << OUT_FRAC_BITS) : 32767;

	logic           en;
	logic [LAT-1:0] vld_q;

	logic [LW-1:0]  lin_r_s1;
	logic [LW-1:0]  lin_g_s1;
	logic [LW-1:0]  lin_b_s1;
	logic [SW-1:0]  sx_s2;
	logic [SW-1:0]  sy_s2;
	logic [SW-1:0]  sz_s2;
	logic [32:0]    nx;
	logic [SW-1:0]  ny;
	logic [32:0]    nz;
	logic [RW-1:0]  xr;
	logic [RW-1:0]  yr;
	logic [RW-1:0]  zr;
	logic [FW-1:0]  fx;
	logic [FW-1:0]  fy;
	logic [FW-1:0]  fz;

	// Global advance: hold only when a result waits on a stalled output
	assign en        = !(vld_q[LAT-1] && lab_stall);
	assign pix_stall = !en;
	assign lab_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pix_valid};
		end
	end

	// Stage 1: gamma table
	always_ff @(posedge clk) begin
		if (en) begin
			lin_r_s1 <= s2lab_pkg::LIN_TABLE[pix_data.red];
			lin_g_s1 <= s2lab_pkg::LIN_TABLE[pix_data.green];
			lin_b_s1 <= s2lab_pkg::LIN_TABLE[pix_data.blue];
		end
	end

	// Stage 2: RGB to XYZ matrix, coefficients times 10000
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= SW'(lin_r_s1) * SW'(4124) + SW'(lin_g_s1) * SW'(3576)
				+ SW'(lin_b_s1) * SW'(1805);
			sy_s2 <= SW'(lin_r_s1) * SW'(2126) + SW'(lin_g_s1) * SW'(7152)
				+ SW'(lin_b_s1) * SW'(722);
			sz_s2 <= SW'(lin_r_s1) * SW'(193) + SW'(lin_g_s1) * SW'(1192)
				+ SW'(lin_b_s1) * SW'(9505);
		end
	end

	// White-point normalization with rounding
	assign nx = 33'(sx_s2) * 33'd10 + 33'd47523;
	assign ny = sy_s2 + SW'(5000);
	assign nz = 33'(sz_s2) * 33'd10 + 33'd54441;

	s2lab_cdiv #(.DIVISOR(95047), .NUM_W(33), .QUO_W(RW)) u_div_x (
		.clk (clk), .en (en), .num (nx), .quo (xr)
	);

	s2lab_cdiv #(.DIVISOR(10000), .NUM_W(SW), .QUO_W(RW)) u_div_y (
		.clk (clk), .en (en), .num (ny), .quo (yr)
	);

	s2lab_cdiv #(.DIVISOR(108883), .NUM_W(33), .QUO_W(RW)) u_div_z (
		.clk (clk), .en (en), .num (nz), .quo (zr)
	);

	// CIELAB f() per component
	s2lab_labf u_f_x (.clk (clk), .en (en), .ratio (xr), .fval (fx));
	s2lab_labf u_f_y (.clk (clk), .en (en), .ratio (yr), .fval (fy));
	s2lab_labf u_f_z (.clk (clk), .en (en), .ratio (zr), .fval (fz));

	// L, a, b and saturation
	s2lab_post #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_post (
		.clk (clk),
		.en  (en),
		.fx  (fx),
		.fy  (fy),
		.fz  (fz),
		.lab (lab_data)
	);

	// Lightness never exceeds 100 on the output scale
	assert property (@(posedge clk) disable iff (!arst_n)
		lab_valid |-> (32'(lab_data.lightness) <= 32'(L_CAP)))
		else $error("lightness above range");

	// A stalled result stays presented
	assert property (@(posedge clk) disable iff (!arst_n)
		lab_valid && lab_stall |=> lab_valid)
		else $error("result dropped under stall");

	// Input back-pressure comes only from a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> lab_valid && lab_stall)
		else $error("input stalled with free output");

endmodule

`default_nettype wire

FILE: src/s2lab_cdiv.sv
// ============================================================================
// s2lab_cdiv
// Three-stage floor division by a constant: reciprocal multiply on the
// upper numerator bits, back-multiply, then remainder correction.
// ============================================================================
`default_nettype none

module s2lab_cdiv #(
	parameter int unsigned DIVISOR = 10000,
	parameter int          NUM_W   = 30,
	parameter int          QUO_W   = 17
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	output logic      [QUO_W-1:0] quo
);

	// Dropped low bits stay below the divisor, so the estimate is short by
	// at most two.
	localparam int SH   = $clog2(DIVISOR) - 1;
	localparam int NH_W = NUM_W - SH;
	localparam int RM_W = $clog2(DIVISOR) + 2;
	localparam longint unsigned RECIP = (64'd1 << NUM_W) / 64'(DIVISOR);
	localparam logic [NH_W-1:0] RECIP_C = NH_W'(RECIP);
	localparam logic [RM_W-1:0] DIV_C   = RM_W'(DIVISOR);
	localparam logic [RM_W-1:0] DIV2_C  = RM_W'(2 * DIVISOR);

	logic [2*NH_W-1:0] prod_s1;
	logic [RM_W-1:0]   low_s1;
	logic [NH_W-1:0]   qe_s2;
	logic [RM_W-1:0]   qd_s2;
	logic [RM_W-1:0]   low_s2;
	logic [NH_W-1:0]   qe;
	logic [RM_W-1:0]   rem;
	logic [NH_W:0]     qfix;

	// Stage 1: reciprocal product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*NH_W)'(num[NUM_W-1:SH]) * (2*NH_W)'(RECIP_C);
			low_s1  <= num[RM_W-1:0];
		end
	end

	assign qe = prod_s1[2*NH_W-1:NH_W];

	// Stage 2: estimate times divisor, low bits only
	always_ff @(posedge clk) begin
		if (en) begin
			qe_s2  <= qe;
			qd_s2  <= RM_W'(qe * DIV_C);
			low_s2 <= low_s1;
		end
	end

	// Stage 3: remainder below three divisors, fix the estimate
	always_comb begin
		rem = low_s2 - qd_s2;
		if (rem >= DIV2_C)
			qfix = (NH_W+1)'(qe_s2) + (NH_W+1)'(2);
		else if (rem >= DIV_C)
			qfix = (NH_W+1)'(qe_s2) + (NH_W+1)'(1);
		else
			qfix = (NH_W+1)'(qe_s2);
	end

	always_ff @(posedge clk) begin
		if (en)
			quo <= QUO_W'(qfix);
	end

endmodule

`default_nettype wire

FILE: src/s2lab_labf.sv
// ============================================================================
// s2lab_labf
// CIELAB f() on a Q16 ratio: a 17-stage digit-by-digit cube root, with the
// linear segment computed alongside and picked at the end.
// ============================================================================
`default_nettype none

module s2lab_labf (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [s2lab_pkg::RATIO_W-1:0] ratio,
	output logic      [s2lab_pkg::F_W-1:0]     fval
);

	localparam int RW    = s2lab_pkg::RATIO_W;
	localparam int FW    = s2lab_pkg::F_W;
	localparam int TGT_W = RW + 32;
	localparam int CND_W = 3 * FW + 2;
	localparam int SQ_W  = 2 * FW;
	localparam int LQ_W  = 15;
	// Cube-root branch for t * 1e6 > 8856 * 65536
	localparam logic [RW-1:0] CUBE_MIN = RW'(581);

	// Per-stage cube-root state; index 0 is the stage input
	logic [TGT_W-1:0] tgt_s [FW+1];
	logic [FW-1:0]    y_s   [FW+1];
	logic [SQ_W-1:0]  y2_s  [FW+1];
	logic [TGT_W-1:0] y3_s  [FW+1];
	logic             big_s [FW+1];

	logic [30:0]      lin_num;
	logic [LQ_W-1:0]  lin_q;
	logic [LQ_W-1:0]  lq_dly_q [FW-3];

	assign tgt_s[0] = {ratio, 32'd0};
	assign y_s[0]   = '0;
	assign y2_s[0]  = '0;
	assign y3_s[0]  = '0;
	assign big_s[0] = ratio >= CUBE_MIN;

	// Cube root: one result bit per stage, cube kept by additions
	for (genvar k = 1; k <= FW; k++) begin : g_root
		localparam int B = FW - k;
		logic [CND_W-1:0] cand;
		logic             fit;

		always_comb begin
			cand = CND_W'(y3_s[k-1])
				+ ((CND_W'(y2_s[k-1]) * CND_W'(3)) << B)
				+ ((CND_W'(y_s[k-1]) * CND_W'(3)) << (2 * B))
				+ (CND_W'(1) << (3 * B));
			fit = cand <= CND_W'(tgt_s[k-1]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tgt_s[k] <= tgt_s[k-1];
				big_s[k] <= big_s[k-1];
				if (fit) begin
					y_s[k]  <= y_s[k-1] | (FW'(1) << B);
					y2_s[k] <= y2_s[k-1] + (SQ_W'(y_s[k-1]) << (B + 1))
						+ (SQ_W'(1) << (2 * B));
					y3_s[k] <= TGT_W'(cand);
				end else begin
					y_s[k]  <= y_s[k-1];
					y2_s[k] <= y2_s[k-1];
					y3_s[k] <= y3_s[k-1];
				end
			end
		end
	end

	// Linear segment: (7787*116 t + 16*65536*1000 + 58000) / 116000
	assign lin_num = 31'(ratio[9:0]) * 31'd903292 + 31'd1048634000;

	s2lab_cdiv #(
		.DIVISOR (116000),
		.NUM_W   (31),
		.QUO_W   (LQ_W)
	) u_lin_div (
		.clk (clk),
		.en  (en),
		.num (lin_num),
		.quo (lin_q)
	);

	// Align linear result with the end of the root pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			lq_dly_q[0] <= lin_q;
			for (int i = 1; i < FW - 3; i++)
				lq_dly_q[i] <= lq_dly_q[i-1];
		end
	end

	// Output select
	always_ff @(posedge clk) begin
		if (en)
			fval <= big_s[FW] ? y_s[FW] : FW'(lq_dly_q[FW-4]);
	end

endmodule

`default_nettype wire

FILE: src/s2lab_post.sv
// ============================================================================
// s2lab_post
// Forms L, a and b from the three f() values, rounds them to the output
// scale and saturates. Two register stages.
// ============================================================================
`default_nettype none

module s2lab_post #(
	parameter int OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [s2lab_pkg::F_W-1:0] fx,
	input  wire logic [s2lab_pkg::F_W-1:0] fy,
	input  wire logic [s2lab_pkg::F_W-1:0] fz,
	output s2lab_pkg::lab_t                 lab
);

	localparam int VW    = 28;
	localparam int SHIFT = 16 - OUT_FRAC_BITS;
	localparam int L_CAP = (100 << OUT_FRAC_BITS) < 32767 ? (100 << OUT_FRAC_BITS) : 32767;
	localparam logic signed [VW-1:0] L_MAX = VW'(L_CAP);
	localparam logic signed [VW-1:0] S_MAX = VW'(32767);
	localparam logic signed [VW-1:0] S_MIN = -VW'(32768);

	logic signed [VW-1:0] vl_s1;
	logic signed [VW-1:0] va_s1;
	logic signed [VW-1:0] vb_s1;
	logic signed [VW-1:0] sl;
	logic signed [VW-1:0] sa;
	logic signed [VW-1:0] sb;

	// Round to nearest, ties away from zero
	function automatic logic signed [VW-1:0] scale(input logic signed [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [VW-1:0] rnd;
		mag = v[VW-1] ? VW'(-v) : VW'(v);
		rnd = (mag + (VW'(1) << (SHIFT - 1))) >> SHIFT;
		return v[VW-1] ? -$signed(rnd) : $signed(rnd);
	endfunction

	// Stage 1: L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), in Q16
	always_ff @(posedge clk) begin
		if (en) begin
			vl_s1 <= $signed(VW'(fy)) * VW'(116) - VW'(1048576);
			va_s1 <= ($signed(VW'(fx)) - $signed(VW'(fy))) * VW'(500);
			vb_s1 <= ($signed(VW'(fy)) - $signed(VW'(fz))) * VW'(200);
		end
	end

	always_comb begin
		sl = scale(vl_s1);
		sa = scale(va_s1);
		sb = scale(vb_s1);
	end

	// Stage 2: clamp to the field ranges
	always_ff @(posedge clk) begin
		if (en) begin
			if (sl < 0)
				lab.lightness <= '0;
			else if (sl > L_MAX)
				lab.lightness <= 15'(L_MAX);
			else
				lab.lightness <= 15'(sl);

			if (sa > S_MAX)
				lab.green_red_axis <= 16'sd32767;
			else if (sa < S_MIN)
				lab.green_red_axis <= -16'sd32768;
			else
				lab.green_red_axis <= 16'(sa);

			if (sb > S_MAX)
				lab.blue_yellow_axis <= 16'sd32767;
			else if (sb < S_MIN)
				lab.blue_yellow_axis <= -16'sd32768;
			else
				lab.blue_yellow_axis <= 16'(sb);
		end
	end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// sRGB to CIELAB converter testbench
// Streams pixels through the converter under several idle/stall mixes and
// compares every L, a, b result with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int FRAC = s2lab_pkg::OUT_FRAC_BITS_DEF;
	localparam int LATENCY = 25;
	localparam int WATCHDOG_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_stall;
	s2lab_pkg::pixel_t pix_data;
	logic              lab_valid;
	logic              lab_stall;
	s2lab_pkg::lab_t   lab_data;

	s2lab_pkg::lab_t expected_lab[$];
	int   send_idle_pct;
	int   recv_stall_pct;
	int   mismatch_count;
	int   pixels_sent;
	int   results_checked;
	int   quiet_cycles;

	srgb_to_cielab_converter_unit #(.OUT_FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
		.lab_valid(lab_valid), .lab_stall(lab_stall), .lab_data(lab_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sRGB gamma expansion to Q0.16
	function automatic longint unsigned srgb_to_linear(input logic [7:0] code);
		longint unsigned t, t2, tgt, lo, hi, mid;
		if (64'(code) * 100000 <= 64'd4045 * 255)
			return (64'(code) * 6553600 + 164730) / 329460;
		t = ((64'd1000 * 64'(code) + 14025) << 30) / 269025;
		t2 = (t * t + (64'd1 << 29)) >> 30;
		tgt = t2 << 30;
		lo = 0;
		hi = 4097;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid * mid * mid * mid <= tgt) lo = mid;
			else hi = mid;
		end
		return (t2 * lo + (64'd1 << 25)) >> 26;
	endfunction

	// CIELAB f(): cube root above the knee, linear segment below
	function automatic longint lab_curve(input longint unsigned t);
		longint unsigned tgt, lo, hi, mid;
		if (t * 1000000 > 64'd8856 * 65536) begin
			tgt = t << 32;
			lo = 0;
			hi = 64'd1 << 17;
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (mid * mid * mid <= tgt) lo = mid;
				else hi = mid;
			end
			return longint'(lo);
		end
		return longint'((64'd7787 * 116 * t + 64'd16000 * 65536 + 58000) / 116000);
	endfunction

	// Q16 to output scale, round half away from zero
	function automatic longint to_out_scale(input longint v);
		longint mag;
		int sh;
		sh = 16 - FRAC;
		if (sh <= 0) return v;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint saturate(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic s2lab_pkg::lab_t predict_lab(input s2lab_pkg::pixel_t px);
		longint unsigned r, g, b, xr, yr, zr;
		longint fx, fy, fz, l, a, bb;
		s2lab_pkg::lab_t res;
		r = srgb_to_linear(px.red);
		g = srgb_to_linear(px.green);
		b = srgb_to_linear(px.blue);
		xr = ((4124 * r + 3576 * g + 1805 * b) * 10 + 47523) / 95047;
		yr = (2126 * r + 7152 * g + 722 * b + 5000) / 10000;
		zr = ((193 * r + 1192 * g + 9505 * b) * 10 + 54441) / 108883;
		fx = lab_curve(xr);
		fy = lab_curve(yr);
		fz = lab_curve(zr);
		l = to_out_scale(116 * fy - 16 * 65536);
		a = to_out_scale(500 * (fx - fy));
		bb = to_out_scale(200 * (fy - fz));
		l = saturate(l, 0, longint'(100) << FRAC);
		l = saturate(l, 0, 32767);
		a = saturate(a, -32768, 32767);
		bb = saturate(bb, -32768, 32767);
		res.lightness = l[14:0];
		res.green_red_axis = a[15:0];
		res.blue_yellow_axis = bb[15:0];
		return res;
	endfunction

	// Send one pixel; returns after its transfer with valid still high
	task automatic send_pixel(input s2lab_pkg::pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= px;
		expected_lab.push_back(predict_lab(px));
		pixels_sent++;
		do @(posedge clk); while (pix_stall);
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		while (expected_lab.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic s2lab_pkg::pixel_t random_pixel();
		s2lab_pkg::pixel_t px;
		px.red = 8'($urandom);
		px.green = 8'($urandom);
		px.blue = 8'($urandom);
		return px;
	endfunction

	// Receiver stall and result checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_stall <= 1'b0;
		end else begin
			if (lab_valid && !lab_stall) begin
				results_checked++;
				if (expected_lab.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result L=%0d a=%0d b=%0d", lab_data.lightness,
							lab_data.green_red_axis, lab_data.blue_yellow_axis);
				end else if (lab_data !== expected_lab[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
							expected_lab[0].lightness, expected_lab[0].green_red_axis,
							expected_lab[0].blue_yellow_axis, lab_data.lightness,
							lab_data.green_red_axis, lab_data.blue_yellow_axis);
					void'(expected_lab.pop_front());
				end else begin
					void'(expected_lab.pop_front());
				end
			end
			lab_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (lab_valid && !lab_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Extremes, primaries, gray steps and both sides of the gamma knee
	task automatic test_directed();
		s2lab_pkg::pixel_t list[$];
		list = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
			'{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0},
			'{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd255}, '{8'd10, 8'd10, 8'd10},
			'{8'd11, 8'd11, 8'd11}, '{8'd10, 8'd11, 8'd12}, '{8'd1, 8'd1, 8'd1},
			'{8'd128, 8'd128, 8'd128}, '{8'd170, 8'd85, 8'd170}, '{8'd85, 8'd170, 8'd85},
			'{8'd20, 8'd20, 8'd20}, '{8'd0, 8'd0, 8'd1}, '{8'd254, 8'd254, 8'd254},
			'{8'd0, 8'd255, 8'd128}, '{8'd128, 8'd0, 8'd255}};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (list[i]) send_pixel(list[i]);
		drain_results();
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			// Dark pixels often, to stay near the linear segments
			if ($urandom_range(3) == 0)
				send_pixel('{8'($urandom_range(16)), 8'($urandom_range(16)),
					8'($urandom_range(16))});
			else
				send_pixel(random_pixel());
		end
	endtask

	// Sender holds off until the pipeline is empty, then resumes
	task automatic test_pause_until_drained();
		send_idle_pct = 0;
		recv_stall_pct = 50;
		for (int i = 0; i < 30; i++) send_pixel(random_pixel());
		pix_valid <= 1'b0;
		while (expected_lab.size() != 0) @(posedge clk);
		for (int i = 0; i < 30; i++) send_pixel(random_pixel());
	endtask

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix_data = '0;
		mismatch_count = 0;
		pixels_sent = 0;
		results_checked = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200, 0, 0);
		test_random(150, 79, 0);
		test_random(150, 0, 79);
		test_random(150, 31, 31);
		test_pause_until_drained();
		test_random(100, 0, 0);
		drain_results();

		$display("%0d pixels sent, %0d results checked over directed, random and",
			pixels_sent, results_checked);
		$display("idle/stall phases; %0d mismatches", mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

`default_nettype wire
